// ===== hw/rtl/grkt_pkg.sv =====
package grkt_pkg;

    localparam int STATIONS  = 8;
    localparam int FRAC_BITS = 16;
    localparam int STN_W     = 3;

    localparam logic signed [63:0] FXONE    = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] KF_T     = (64'sd624 * FXONE + 64'sd500) / 64'sd1000;
    localparam logic signed [63:0] SIG_R    = FXONE / 64'sd2;
    localparam logic signed [63:0] SIG_V    = (64'sd3 * FXONE + 64'sd5) / 64'sd10;
    localparam logic signed [63:0] NOISE_R  = 64'sd50 * FXONE;
    localparam logic signed [63:0] NOISE_V  = 64'sd20 * FXONE;
    localparam logic signed [31:0] VAR_INIT = 32'(64'sd10 * FXONE);

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef enum logic [0:0] {
        CFG_STEP_GATE = 1'b0,
        CFG_GAP_LIMIT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
    } mul_req_t;

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            if (v > S32_MAX)
            begin
                r = S32_MAX;
            end
            else if (v < S32_MIN)
            begin
                r = S32_MIN;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/gated_range_kalman_tracker.sv =====
// Gated range tracker: one ranging sample per beat on the s_axis channel,
// one smoothed result per beat on the m_axis channel.
// s_axis_tdata carries station and range_in; m_axis_tdata carries station_out,
// fit_range, fit_rate and fit_valid. Configuration registers step_gate
// (index 0) and gap_limit (index 1) are written through cfg_we/cfg_addr/
// cfg_wdata; the user must write them only while the block is idle, and the
// block itself does not enforce it. A warm-up sample (one of the first five
// per station) passes through unfiltered. A tracked sample runs the Kalman
// update through one shared registered multiplier and a bit-serial divider:
// a sequence of multiplier steps plus four divisions.
// s_axis_tready is high only while no sample is in work; a result is held in
// the output register until it is taken, and the next sample is accepted only
// once the sequencer is idle and the output register is empty.
// Reset clears all per-station tracks to their initial state (variances 10.0)
// and restores step_gate 90 and gap_limit 3. A stalled receiver just holds
// the result beat; no sample is lost.
module gated_range_kalman_tracker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // station[2:0], range_in[33:3], zero fill
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // station_out[2:0], fit_range[34:3],
                                         // fit_rate[66:35], fit_valid[67], zero fill
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [9:0]   cfg_wdata
);
    import grkt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_MUL, ST_MWAIT, ST_DIV, ST_DWAIT, ST_FIN, ST_OUT
    } state_t;

    typedef logic signed [31:0] w32_t;

    state_t state_reg;
    logic [9:0]  step_gate_reg;
    logic [3:0]  gap_limit_reg;

    logic [2:0] warm_count_reg [STATIONS];
    w32_t prev_raw_reg [STATIONS];
    w32_t last_fit_reg [STATIONS];
    w32_t wsum_reg [STATIONS];
    logic [2:0] wpairs_reg [STATIONS];
    logic [7:0] gap_reg [STATIONS];
    w32_t est_r_reg [STATIONS];
    w32_t est_v_reg [STATIONS];
    w32_t var_r_reg [STATIONS];
    w32_t var_v_reg [STATIONS];
    w32_t hold_r_reg [STATIONS];
    w32_t hold_v_reg [STATIONS];

    logic [STN_W-1:0] stn_reg;
    logic signed [63:0] raw_reg;
    logic signed [63:0] zv_reg;
    logic reacq_reg;
    logic [5:0] step_reg;
    logic [1:0] dstep_reg;
    logic signed [63:0] r_reg [24];
    logic signed [63:0] det_reg;
    logic signed [31:0] o_range_reg, o_rate_reg;
    logic div_start;

    mul_req_t mreq;
    logic signed [63:0] mq;
    logic signed [63:0] dnum;
    logic div_busy;
    logic signed [63:0] dquo;

    grkt_mul u_mul (.clk(clk), .req(mreq), .q(mq));
    grkt_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(dnum),
                    .den(det_reg), .busy(div_busy), .quo(dquo));

    logic [STN_W-1:0] in_stn;
    logic signed [63:0] in_raw;
    assign in_stn = s_axis_tdata[2:0];
    assign in_raw = {33'd0, s_axis_tdata[33:3]};
    assign s_axis_tready = (state_reg == ST_IDLE) && !m_axis_tvalid;

    // Register map of scratch file r_reg (sat32 values but 0, 1, 9, 23):
    // 0 tp, 1 tt, 3 a00, 4 a01, 5 a10, 6 a11, 7 s00, 8 s10, 9 det parts
    // 10..13 m, 14..17 g*m, 18..21 k, 22 pr, 23 temp.
    logic signed [63:0] g0, g1, i0, i1;
    assign g0 = reacq_reg ? FXONE : SIG_R;
    assign g1 = reacq_reg ? FXONE : SIG_V;
    assign i0 = sat32(raw_reg - r_reg[22]);
    assign i1 = sat32(zv_reg - 64'(est_v_reg[stn_reg]));

    always_comb
    begin
        mreq.a = 32'sd0;
        mreq.b = 32'sd0;
        unique case (step_reg)
            6'd0:  begin mreq.a = 32'(KF_T); mreq.b = var_v_reg[stn_reg]; end
            6'd1:  begin mreq.a = 32'(KF_T); mreq.b = 32'(KF_T); end
            6'd2:  begin mreq.a = 32'(r_reg[1]); mreq.b = var_v_reg[stn_reg]; end
            6'd3:  begin mreq.a = 32'(r_reg[7]); mreq.b = 32'(r_reg[6]); end
            6'd4:  begin mreq.a = 32'(r_reg[4]); mreq.b = 32'(r_reg[8]); end
            6'd5:  begin mreq.a = 32'(r_reg[3]); mreq.b = 32'(r_reg[6]); end
            6'd6:  begin mreq.a = 32'(r_reg[4]); mreq.b = 32'(sat32(-r_reg[8])); end
            6'd7:  begin mreq.a = 32'(r_reg[3]); mreq.b = 32'(sat32(-r_reg[4])); end
            6'd8:  begin mreq.a = 32'(r_reg[4]); mreq.b = 32'(r_reg[7]); end
            6'd9:  begin mreq.a = 32'(r_reg[5]); mreq.b = 32'(r_reg[6]); end
            6'd10: begin mreq.a = 32'(r_reg[6]); mreq.b = 32'(sat32(-r_reg[8])); end
            6'd11: begin mreq.a = 32'(r_reg[5]); mreq.b = 32'(sat32(-r_reg[4])); end
            6'd12: begin mreq.a = 32'(r_reg[6]); mreq.b = 32'(r_reg[7]); end
            6'd13: begin mreq.a = 32'(g0); mreq.b = 32'(r_reg[10]); end
            6'd14: begin mreq.a = 32'(g0); mreq.b = 32'(r_reg[11]); end
            6'd15: begin mreq.a = 32'(g1); mreq.b = 32'(r_reg[12]); end
            6'd16: begin mreq.a = 32'(g1); mreq.b = 32'(r_reg[13]); end
            6'd17: begin mreq.a = 32'(KF_T); mreq.b = est_v_reg[stn_reg]; end
            6'd18: begin mreq.a = 32'(r_reg[18]); mreq.b = 32'(i0); end
            6'd19: begin mreq.a = 32'(r_reg[19]); mreq.b = 32'(i1); end
            6'd20: begin mreq.a = 32'(r_reg[20]); mreq.b = 32'(i0); end
            6'd21: begin mreq.a = 32'(r_reg[21]); mreq.b = 32'(i1); end
            6'd22: begin mreq.a = 32'(FXONE - r_reg[18]); mreq.b = 32'(r_reg[3]); end
            6'd23: begin mreq.a = 32'(r_reg[19]); mreq.b = 32'(r_reg[5]); end
            6'd24: begin mreq.a = 32'(FXONE - r_reg[21]); mreq.b = 32'(r_reg[6]); end
            6'd25: begin mreq.a = 32'(r_reg[20]); mreq.b = 32'(r_reg[4]); end
            default: begin mreq.a = 32'sd0; mreq.b = 32'sd0; end
        endcase
    end

    assign dnum = r_reg[14 + 32'(dstep_reg)] * FXONE;
    assign div_start = (state_reg == ST_DIV);

    logic signed [63:0] mulq_fix;
    logic signed [63:0] pfull;
    // Round toward minus infinity of the magnitude-based rounding in the
    // model: the shift floors both signs, matching -ceil(|p|) for negatives.
    assign pfull = 64'(mreq.a) * 64'(mreq.b);
    assign mulq_fix = mq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_gate_reg <= 10'd90;
            gap_limit_reg <= 4'd3;
            m_axis_tvalid <= 1'b0;
            step_reg      <= 6'd0;
            dstep_reg     <= 2'd0;
            for (int i = 0; i < STATIONS; i++)
            begin
                warm_count_reg[i] <= 3'd0;
                prev_raw_reg[i]   <= 32'sd0;
                last_fit_reg[i]   <= 32'sd0;
                wsum_reg[i]       <= 32'sd0;
                wpairs_reg[i]     <= 3'd0;
                gap_reg[i]        <= 8'd0;
                est_r_reg[i]      <= 32'sd0;
                est_v_reg[i]      <= 32'sd0;
                var_r_reg[i]      <= VAR_INIT;
                var_v_reg[i]      <= VAR_INIT;
                hold_r_reg[i]     <= 32'sd0;
                hold_v_reg[i]     <= 32'sd0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_STEP_GATE: step_gate_reg <= cfg_wdata;
                    CFG_GAP_LIMIT: gap_limit_reg <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        stn_reg   <= in_stn;
                        raw_reg   <= in_raw;
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin : decide
                    logic [2:0] w;
                    logic [7:0] g, gi;
                    logic signed [63:0] delta, last, hv, thr, d;
                    w     = warm_count_reg[stn_reg];
                    g     = gap_reg[stn_reg];
                    gi    = (g == 8'd255) ? 8'd255 : g + 8'd1;
                    delta = raw_reg - 64'(prev_raw_reg[stn_reg]);
                    last  = 64'(last_fit_reg[stn_reg]);
                    hv    = 64'(hold_v_reg[stn_reg]);
                    prev_raw_reg[stn_reg] <= 32'(raw_reg);
                    state_reg <= ST_OUT;
                    step_reg  <= 6'd0;
                    reacq_reg <= 1'b0;
                    zv_reg    <= delta;
                    if (w < 3'd5)
                    begin : warm
                        logic signed [63:0] sum;
                        logic [2:0] np;
                        sum = 64'(wsum_reg[stn_reg]);
                        np  = wpairs_reg[stn_reg];
                        o_range_reg <= 32'(raw_reg);
                        o_rate_reg  <= (w == 3'd0) ? 32'sd0 : 32'(delta);
                        if (w != 3'd0 && raw_reg != 64'sd0 && prev_raw_reg[stn_reg] != 32'sd0)
                        begin
                            sum = sat32(sum + delta);
                            np  = np + 3'd1;
                        end
                        wsum_reg[stn_reg]   <= 32'(sum);
                        wpairs_reg[stn_reg] <= np;
                        if (w == 3'd4)
                        begin
                            est_r_reg[stn_reg]  <= 32'(raw_reg);
                            hold_r_reg[stn_reg] <= 32'(raw_reg);
                            // At most four pairs, a small constant division.
                            unique case (np)
                                3'd0: est_v_reg[stn_reg] <= 32'sd0;
                                3'd1: est_v_reg[stn_reg] <= 32'(sum);
                                3'd2: est_v_reg[stn_reg] <= 32'(sum / 64'sd2);
                                3'd3: est_v_reg[stn_reg] <= 32'(sum / 64'sd3);
                                default: est_v_reg[stn_reg] <= 32'(sum / 64'sd4);
                            endcase
                        end
                        warm_count_reg[stn_reg] <= w + 3'd1;
                    end
                    else if (raw_reg == 64'sd0)
                    begin
                        gap_reg[stn_reg] <= gi;
                        if (gi > 8'(gap_limit_reg))
                        begin
                            o_range_reg <= 32'sd0;
                            o_rate_reg  <= 32'sd0;
                        end
                        else
                        begin
                            o_range_reg <= 32'(sat32(last + hv));
                            o_rate_reg  <= 32'(hv);
                            hold_r_reg[stn_reg] <= 32'(sat32(last + hv));
                        end
                    end
                    else if (g > 8'(gap_limit_reg))
                    begin
                        thr = 64'(step_gate_reg) * (64'(g) + 64'sd1 - 64'(gap_limit_reg))
                              * FXONE;
                        d = raw_reg - 64'(hold_r_reg[stn_reg]);
                        if (d < 0)
                        begin
                            d = -d;
                        end
                        if (d > thr)
                        begin
                            gap_reg[stn_reg] <= gi;
                            o_range_reg <= 32'sd0;
                            o_rate_reg  <= 32'sd0;
                        end
                        else
                        begin
                            zv_reg    <= 64'sd0;
                            est_r_reg[stn_reg] <= 32'(raw_reg);
                            est_v_reg[stn_reg] <= 32'sd0;
                            reacq_reg <= 1'b1;
                            gap_reg[stn_reg] <= 8'd0;
                            state_reg <= ST_MUL;
                        end
                    end
                    else
                    begin
                        d = raw_reg - last;
                        if (d < 0)
                        begin
                            d = -d;
                        end
                        if (d > 64'(step_gate_reg) * FXONE)
                        begin
                            gap_reg[stn_reg] <= gi;
                            o_rate_reg  <= 32'(hv);
                            o_range_reg <= (gi > 8'(gap_limit_reg)) ? 32'sd0
                                           : 32'(sat32(last + hv));
                        end
                        else
                        begin
                            if (g != 8'd0)
                            begin
                                zv_reg <= hv;
                            end
                            gap_reg[stn_reg] <= 8'd0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_MWAIT;
                end
                ST_MWAIT:
                begin : mw
                    logic signed [63:0] p0;
                    p0 = 64'(var_r_reg[stn_reg]);
                    state_reg <= ST_MUL;
                    step_reg  <= step_reg + 6'd1;
                    unique case (step_reg)
                        6'd0: r_reg[0] <= mulq_fix;
                        6'd1: r_reg[1] <= mulq_fix;
                        6'd2:
                        begin
                            r_reg[3] <= sat32(p0 + mulq_fix + NOISE_R);
                            r_reg[4] <= sat32(r_reg[0]);
                            r_reg[5] <= sat32(r_reg[0] + NOISE_V);
                            r_reg[6] <= 64'(var_v_reg[stn_reg]);
                            r_reg[7] <= sat32(sat32(p0 + mulq_fix + NOISE_R) + NOISE_R);
                            r_reg[8] <= sat32(sat32(r_reg[0] + NOISE_V) + NOISE_V);
                        end
                        6'd3: r_reg[9] <= mulq_fix;
                        6'd4:
                        begin
                            det_reg <= r_reg[9] - mulq_fix;
                            if (r_reg[9] - mulq_fix <= 64'sd0)
                            begin
                                est_r_reg[stn_reg] <= 32'(raw_reg);
                                est_v_reg[stn_reg] <= 32'(zv_reg);
                                var_r_reg[stn_reg] <= 32'(r_reg[3]);
                                var_v_reg[stn_reg] <= 32'(r_reg[6]);
                                o_range_reg <= 32'(raw_reg);
                                o_rate_reg  <= 32'(zv_reg);
                                state_reg <= ST_FIN;
                            end
                        end
                        6'd5, 6'd7, 6'd9, 6'd11: r_reg[23] <= mulq_fix;
                        6'd6:  r_reg[10] <= sat32(r_reg[23] + mulq_fix);
                        6'd8:  r_reg[11] <= sat32(r_reg[23] + mulq_fix);
                        6'd10: r_reg[12] <= sat32(r_reg[23] + mulq_fix);
                        6'd12: r_reg[13] <= sat32(r_reg[23] + mulq_fix);
                        6'd13: r_reg[14] <= sat32(mulq_fix);
                        6'd14: r_reg[15] <= sat32(mulq_fix);
                        6'd15: r_reg[16] <= sat32(mulq_fix);
                        6'd16:
                        begin
                            r_reg[17] <= sat32(mulq_fix);
                            dstep_reg <= 2'd0;
                            state_reg <= ST_DIV;
                        end
                        6'd17: r_reg[22] <= sat32(64'(est_r_reg[stn_reg]) + mulq_fix);
                        6'd18: r_reg[23] <= mulq_fix;
                        6'd19:
                        begin
                            o_range_reg <= 32'(sat32(r_reg[22] + r_reg[23] + mulq_fix));
                        end
                        6'd20: r_reg[23] <= mulq_fix;
                        6'd21:
                        begin
                            o_rate_reg <= 32'(sat32(64'(est_v_reg[stn_reg]) + r_reg[23]
                                                    + mulq_fix));
                        end
                        6'd22: r_reg[23] <= mulq_fix;
                        6'd23: var_r_reg[stn_reg] <= 32'(sat32(r_reg[23] - mulq_fix));
                        6'd24: r_reg[23] <= mulq_fix;
                        default:
                        begin
                            var_v_reg[stn_reg] <= 32'(sat32(r_reg[23] - mulq_fix));
                            est_r_reg[stn_reg] <= o_range_reg;
                            est_v_reg[stn_reg] <= o_rate_reg;
                            state_reg <= ST_FIN;
                        end
                    endcase
                end
                ST_DIV:
                begin
                    state_reg <= ST_DWAIT;
                end
                ST_DWAIT:
                begin
                    if (!div_busy)
                    begin
                        r_reg[18 + 32'(dstep_reg)] <= sat32(dquo);
                        dstep_reg <= dstep_reg + 2'd1;
                        state_reg <= (dstep_reg == 2'd3) ? ST_MUL : ST_DIV;
                    end
                end
                ST_FIN:
                begin
                    hold_r_reg[stn_reg] <= o_range_reg;
                    hold_v_reg[stn_reg] <= o_rate_reg;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    last_fit_reg[stn_reg] <= o_range_reg;
                    m_axis_tvalid <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = {4'd0, (o_range_reg != 32'sd0), o_rate_reg, o_range_reg, stn_reg};

    logic unused_ok;
    assign unused_ok = ^pfull;

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sample accepted while another is in work");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> m_axis_tvalid)
        else $error("result not loaded into output register");
    assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == ST_DWAIT))
        else $error("divider running outside its wait state");

endmodule

// ===== hw/rtl/grkt_mul.sv =====
module grkt_mul
(
    input  logic                clk,
    input  grkt_pkg::mul_req_t  req,
    output logic signed [63:0]  q
);
    import grkt_pkg::*;

    logic signed [63:0] p;
    logic signed [63:0] q_next;

    // Q-format product, floored toward minus infinity by the arithmetic shift.
    assign p      = 64'(req.a) * 64'(req.b);
    assign q_next = p >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        q <= q_next;
    end

endmodule

// ===== hw/rtl/grkt_div.sv =====
module grkt_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic               busy,
    output logic signed [63:0] quo
);
    import grkt_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] qa_reg, qa_next;
    logic [63:0] dv_reg, dv_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [64:0] trial;

    assign busy  = (cnt_reg != 7'd0);
    assign trial = {rem_reg, qa_reg[63]} - {1'b0, dv_reg};
    assign quo   = neg_reg ? -$signed(qa_reg) : $signed(qa_reg);

    // Restoring division, one quotient bit per cycle, truncating toward zero.
    always_comb
    begin
        rem_next = rem_reg;
        qa_next  = qa_reg;
        dv_next  = dv_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        if (start)
        begin
            rem_next = 64'd0;
            qa_next  = num[63] ? 64'(-num) : 64'(num);
            dv_next  = 64'(den);
            neg_next = num[63];
            cnt_next = 7'd64;
        end
        else if (busy)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                qa_next  = {qa_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], qa_reg[63]};
                qa_next  = {qa_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 7'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qa_reg  <= qa_next;
        dv_reg  <= dv_next;
        neg_reg <= neg_next;
    end

endmodule
